// File: design/csm_pkg.sv
package csm_pkg;

    localparam int MAX_SIDE    = 256;
    localparam int POS_W       = $clog2(MAX_SIDE);
    localparam int SIDE_W      = POS_W + 1;
    localparam int ADDR_W      = 2 * POS_W;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int MIN_SIDE    = 4;

    localparam int CFG_W       = 9;
    localparam int COORD_W     = 16;
    localparam int INDEX_W     = 16;
    localparam int COMP_W      = 8;
    localparam int TEXEL_W     = 16;
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = COORD_W + SIDE_W;

    localparam int RED_W       = 7;
    localparam int GREEN_W     = 8;
    localparam int BLUE_W      = 7;

    localparam int MARGIN_LOW  = 655;
    localparam int MARGIN_HIGH = 64881;
    localparam int HALF_ULP    = 32768;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_W-1:0] RESET_SIDE = CFG_W'(256);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    typedef enum logic [1:0]
    {
        KIND_WRITE,
        KIND_QUERY,
        KIND_BORDER
    } kind_t;

    typedef struct packed
    {
        kind_t               kind;
        logic [ADDR_W-1:0]   addr0;
        logic [ADDR_W-1:0]   addr1;
        logic [ADDR_W-1:0]   addr2;
        logic [TEXEL_W-1:0]  texel;
    } entry_t;

    function automatic logic [SIDE_W-1:0] effective_size(input logic [CFG_W-1:0] raw);
        logic [SIDE_W-1:0] size;
        if (raw < CFG_W'(MIN_SIDE))
        begin
            size = SIDE_W'(MIN_SIDE);
        end
        else if (raw > CFG_W'(MAX_SIDE))
        begin
            size = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            size = SIDE_W'(raw);
        end
        return size;
    endfunction

    function automatic logic [TEXEL_W-1:0] to_rgb565(input logic [COMP_W-1:0] r,
                                                     input logic [COMP_W-1:0] g,
                                                     input logic [COMP_W-1:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

// File: design/three_tap_color_map_sampler_top.sv
// three-tap rgb565 color map sampler
// input channel: in_valid / in_stall with cmd, coord_x, coord_y, texel_index and
// red_in, green_in, blue_in. cmd write stores one texel converted to rgb565 and
// gives no result word; cmd query gives one result word.
// output channel: out_valid / out_stall with red_sum, green_sum, blue_sum and
// at_border. a query in the margin gives zero sums with at_border set.
// config: cfg_we, cfg_index, cfg_data write map_width (0) or map_height (1);
// write only while the block is idle.
// a query reads the single-port texel store three times, one tap after
// another, before it leaves the queue; a write, or a margin query once a
// result slot is free, leaves the queue as soon as it reaches the head.
// a 4-word queue sits between the address front end and the store, and a
// 2-word result buffer lets input words keep flowing while a result waits.
// reset: both sizes return to 256, queue and result buffer empty; the texel
// store is not cleared and holds garbage until written.
// a stalled output holds its word; the queue fills and then in_stall rises.
module three_tap_color_map_sampler_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [csm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [csm_pkg::COORD_W-1:0]   coord_x,
    input  logic [csm_pkg::COORD_W-1:0]   coord_y,
    input  logic [csm_pkg::INDEX_W-1:0]   texel_index,
    input  logic [csm_pkg::COMP_W-1:0]    red_in,
    input  logic [csm_pkg::COMP_W-1:0]    green_in,
    input  logic [csm_pkg::COMP_W-1:0]    blue_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [csm_pkg::RED_W-1:0]     red_sum,
    output logic [csm_pkg::GREEN_W-1:0]   green_sum,
    output logic [csm_pkg::BLUE_W-1:0]    blue_sum,
    output logic                          at_border
);
    import csm_pkg::*;

    logic   push;
    entry_t push_entry;
    logic   queue_full;
    logic   pop;
    logic   head_valid;
    entry_t head;

    csm_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .texel_index (texel_index),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .push        (push),
        .push_entry  (push_entry),
        .queue_full  (queue_full)
    );

    csm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    csm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_sum    (red_sum),
        .green_sum  (green_sum),
        .blue_sum   (blue_sum),
        .at_border  (at_border)
    );

endmodule

// File: design/csm_front.sv
module csm_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [csm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [csm_pkg::COORD_W-1:0]   coord_x,
    input  logic [csm_pkg::COORD_W-1:0]   coord_y,
    input  logic [csm_pkg::INDEX_W-1:0]   texel_index,
    input  logic [csm_pkg::COMP_W-1:0]    red_in,
    input  logic [csm_pkg::COMP_W-1:0]    green_in,
    input  logic [csm_pkg::COMP_W-1:0]    blue_in,
    output logic                          push,
    output csm_pkg::entry_t               push_entry,
    input  logic                          queue_full
);
    import csm_pkg::*;

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;

    logic               s1_valid_reg;
    kind_t              s1_kind_reg;
    logic [PROD_W-1:0]  s1_px_reg;
    logic [PROD_W-1:0]  s1_py_reg;
    logic [SIDE_W-1:0]  s1_w_reg;
    logic [SIDE_W-1:0]  s1_h_reg;
    logic [ADDR_W-1:0]  s1_waddr_reg;
    logic [TEXEL_W-1:0] s1_texel_reg;

    logic               s2_valid_reg;
    kind_t              s2_kind_reg;
    logic [POS_W-1:0]   s2_bx_reg;
    logic [POS_W-1:0]   s2_by_reg;
    logic [POS_W-1:0]   s2_rx_reg;
    logic [POS_W-1:0]   s2_ry_reg;
    logic [SIDE_W-1:0]  s2_w_reg;
    logic [ADDR_W-1:0]  s2_waddr_reg;
    logic [TEXEL_W-1:0] s2_texel_reg;

    logic               in_accept;
    logic               write_ok;
    logic               in_margin;
    logic               s1_valid_next;
    kind_t              s1_kind_next;
    logic               s1_load;
    logic               s2_load;
    logic [SIDE_W-1:0]  eff_w;
    logic [SIDE_W-1:0]  eff_h;
    logic [POS_W-1:0]   bx_next;
    logic [POS_W-1:0]   by_next;
    logic [POS_W-1:0]   rx_next;
    logic [POS_W-1:0]   ry_next;
    logic [POS_W+SIDE_W-1:0] row_base;
    logic [POS_W+SIDE_W-1:0] row_round;

    function automatic logic [POS_W-1:0] base_clamp(input logic [PROD_W-1:0] prod,
                                                    input logic [SIDE_W-1:0] size);
        logic [SIDE_W-1:0] fl;
        logic [SIDE_W-1:0] pos;
        fl = prod[PROD_W-1:FRAC_W];
        if (fl < SIDE_W'(1))
        begin
            pos = SIDE_W'(1);
        end
        else if (fl > size - SIDE_W'(2))
        begin
            pos = size - SIDE_W'(2);
        end
        else
        begin
            pos = fl;
        end
        return POS_W'(pos);
    endfunction

    function automatic logic [POS_W-1:0] round_clamp(input logic [PROD_W-1:0] prod,
                                                     input logic [SIDE_W-1:0] size);
        logic [PROD_W:0]   sum;
        logic [SIDE_W:0]   rn;
        logic [SIDE_W:0]   pos;
        sum = {1'b0, prod} + (PROD_W+1)'(HALF_ULP);
        rn  = sum[PROD_W:FRAC_W];
        if (rn > {1'b0, size} - (SIDE_W+1)'(1))
        begin
            pos = {1'b0, size} - (SIDE_W+1)'(1);
        end
        else
        begin
            pos = rn;
        end
        return POS_W'(pos);
    endfunction

    assign eff_w = effective_size(width_reg);
    assign eff_h = effective_size(height_reg);

    assign s2_load   = !s2_valid_reg || !queue_full;
    assign s1_load   = !s1_valid_reg || s2_load;
    assign in_stall  = !s1_load;
    assign in_accept = in_valid && !in_stall;

    assign write_ok  = (32'(texel_index) < STORE_DEPTH);
    assign in_margin = (coord_x <= COORD_W'(MARGIN_LOW)) || (coord_x >= COORD_W'(MARGIN_HIGH))
                    || (coord_y <= COORD_W'(MARGIN_LOW)) || (coord_y >= COORD_W'(MARGIN_HIGH));

    always_comb
    begin
        s1_valid_next = in_accept;
        if (cmd == CMD_WRITE)
        begin
            s1_kind_next = KIND_WRITE;
            if (!write_ok)
            begin
                s1_valid_next = 1'b0;
            end
        end
        else if (in_margin)
        begin
            s1_kind_next = KIND_BORDER;
        end
        else
        begin
            s1_kind_next = KIND_QUERY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= RESET_SIDE;
            height_reg   <= RESET_SIDE;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_MAP_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_MAP_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
            if (s1_load)
            begin
                s1_valid_reg <= s1_valid_next;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg  <= s1_kind_next;
            s1_px_reg    <= PROD_W'(coord_x * eff_w);
            s1_py_reg    <= PROD_W'(coord_y * eff_h);
            s1_w_reg     <= eff_w;
            s1_h_reg     <= eff_h;
            s1_waddr_reg <= ADDR_W'(texel_index);
            s1_texel_reg <= to_rgb565(red_in, green_in, blue_in);
        end
    end

    assign bx_next = base_clamp(s1_px_reg, s1_w_reg);
    assign by_next = base_clamp(s1_py_reg, s1_h_reg);
    assign rx_next = round_clamp(s1_px_reg, s1_w_reg);
    assign ry_next = round_clamp(s1_py_reg, s1_h_reg);

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            s2_kind_reg  <= s1_kind_reg;
            s2_bx_reg    <= bx_next;
            s2_by_reg    <= by_next;
            s2_rx_reg    <= rx_next;
            s2_ry_reg    <= ry_next;
            s2_w_reg     <= s1_w_reg;
            s2_waddr_reg <= s1_waddr_reg;
            s2_texel_reg <= s1_texel_reg;
        end
    end

    assign row_base  = s2_by_reg * s2_w_reg;
    assign row_round = s2_ry_reg * s2_w_reg;

    always_comb
    begin
        push_entry.kind  = s2_kind_reg;
        push_entry.texel = s2_texel_reg;
        push_entry.addr1 = ADDR_W'(row_base + (POS_W+SIDE_W)'(s2_rx_reg));
        push_entry.addr2 = ADDR_W'(row_round + (POS_W+SIDE_W)'(s2_bx_reg));
        if (s2_kind_reg == KIND_WRITE)
        begin
            push_entry.addr0 = s2_waddr_reg;
        end
        else
        begin
            push_entry.addr0 = ADDR_W'(row_base + (POS_W+SIDE_W)'(s2_bx_reg));
        end
    end

    assign push = s2_valid_reg && !queue_full;

endmodule

// File: design/csm_queue.sv
module csm_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  csm_pkg::entry_t   push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output csm_pkg::entry_t   head
);
    import csm_pkg::*;

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_entry;
        end
    end

endmodule

// File: design/csm_back.sv
module csm_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  csm_pkg::entry_t               head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [csm_pkg::RED_W-1:0]     red_sum,
    output logic [csm_pkg::GREEN_W-1:0]   green_sum,
    output logic [csm_pkg::BLUE_W-1:0]    blue_sum,
    output logic                          at_border
);
    import csm_pkg::*;

    localparam int RES_DEPTH = 2;

    typedef enum logic [1:0]
    {
        ST_FIRST,
        ST_SECOND,
        ST_THIRD
    } state_t;

    typedef struct packed
    {
        logic valid;
        logic first;
        logic last;
        logic border;
    } tag_t;

    typedef struct packed
    {
        logic [RED_W-1:0]   red;
        logic [GREEN_W-1:0] green;
        logic [BLUE_W-1:0]  blue;
        logic               border;
    } result_t;

    logic [TEXEL_W-1:0] store_mem [STORE_DEPTH];

    state_t             state_reg;
    state_t             state_next;
    tag_t               tag_reg;
    tag_t               tag_next;
    logic [TEXEL_W-1:0] rdata_reg;
    logic [RED_W-1:0]   acc_r_reg;
    logic [GREEN_W-1:0] acc_g_reg;
    logic [BLUE_W-1:0]  acc_b_reg;
    logic [1:0]         used_reg;
    logic [1:0]         used_next;

    result_t            res_reg [RES_DEPTH];
    logic               res_wptr_reg;
    logic               res_rptr_reg;
    logic [1:0]         res_cnt_reg;
    logic [1:0]         res_cnt_next;

    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic               credit_ok;
    logic               take_credit;
    logic               out_pop;
    logic               res_push;
    result_t            res_new;
    logic [RED_W-1:0]   sum_r;
    logic [GREEN_W-1:0] sum_g;
    logic [BLUE_W-1:0]  sum_b;

    assign out_pop   = out_valid && !out_stall;
    assign credit_ok = (used_reg != 2'(RES_DEPTH)) || out_pop;

    always_comb
    begin
        state_next  = state_reg;
        tag_next    = '0;
        pop         = 1'b0;
        take_credit = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = head.addr0;
        unique case (state_reg)
            ST_FIRST:
            begin
                if (head_valid)
                begin
                    unique case (head.kind)
                        KIND_WRITE:
                        begin
                            mem_we = 1'b1;
                            pop    = 1'b1;
                        end
                        KIND_BORDER:
                        begin
                            if (credit_ok)
                            begin
                                pop         = 1'b1;
                                take_credit = 1'b1;
                                tag_next    = '{valid: 1'b1, first: 1'b1, last: 1'b1,
                                                border: 1'b1};
                            end
                        end
                        KIND_QUERY:
                        begin
                            if (credit_ok)
                            begin
                                mem_re      = 1'b1;
                                take_credit = 1'b1;
                                tag_next    = '{valid: 1'b1, first: 1'b1, last: 1'b0,
                                                border: 1'b0};
                                state_next  = ST_SECOND;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SECOND:
            begin
                mem_re     = 1'b1;
                mem_addr   = head.addr1;
                tag_next   = '{valid: 1'b1, first: 1'b0, last: 1'b0, border: 1'b0};
                state_next = ST_THIRD;
            end
            ST_THIRD:
            begin
                mem_re     = 1'b1;
                mem_addr   = head.addr2;
                pop        = 1'b1;
                tag_next   = '{valid: 1'b1, first: 1'b0, last: 1'b1, border: 1'b0};
                state_next = ST_FIRST;
            end
            default:
            begin
                state_next = ST_FIRST;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= head.texel;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[mem_addr];
        end
    end

    always_comb
    begin
        if (tag_reg.first)
        begin
            sum_r = RED_W'(rdata_reg[15:11]);
            sum_g = GREEN_W'(rdata_reg[10:5]);
            sum_b = BLUE_W'(rdata_reg[4:0]);
        end
        else
        begin
            sum_r = acc_r_reg + RED_W'(rdata_reg[15:11]);
            sum_g = acc_g_reg + GREEN_W'(rdata_reg[10:5]);
            sum_b = acc_b_reg + BLUE_W'(rdata_reg[4:0]);
        end
        res_push = tag_reg.valid && tag_reg.last;
        if (tag_reg.border)
        begin
            res_new = '{red: '0, green: '0, blue: '0, border: 1'b1};
        end
        else
        begin
            res_new = '{red: sum_r, green: sum_g, blue: sum_b, border: 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_reg.valid && !tag_reg.last)
        begin
            acc_r_reg <= sum_r;
            acc_g_reg <= sum_g;
            acc_b_reg <= sum_b;
        end
        if (res_push)
        begin
            res_reg[res_wptr_reg] <= res_new;
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (take_credit && !out_pop)
        begin
            used_next = used_reg + 2'd1;
        end
        else if (out_pop && !take_credit)
        begin
            used_next = used_reg - 2'd1;
        end
        res_cnt_next = res_cnt_reg;
        if (res_push && !out_pop)
        begin
            res_cnt_next = res_cnt_reg + 2'd1;
        end
        else if (out_pop && !res_push)
        begin
            res_cnt_next = res_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FIRST;
            tag_reg      <= '0;
            used_reg     <= '0;
            res_wptr_reg <= 1'b0;
            res_rptr_reg <= 1'b0;
            res_cnt_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            tag_reg     <= tag_next;
            used_reg    <= used_next;
            res_cnt_reg <= res_cnt_next;
            if (res_push)
            begin
                res_wptr_reg <= !res_wptr_reg;
            end
            if (out_pop)
            begin
                res_rptr_reg <= !res_rptr_reg;
            end
        end
    end

    assign out_valid = (res_cnt_reg != 2'd0);
    assign red_sum   = res_reg[res_rptr_reg].red;
    assign green_sum = res_reg[res_rptr_reg].green;
    assign blue_sum  = res_reg[res_rptr_reg].blue;
    assign at_border = res_reg[res_rptr_reg].border;

endmodule

// File: design/csm_checker.sv
module csm_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [csm_pkg::RED_W-1:0]     red_sum,
    input  logic [csm_pkg::GREEN_W-1:0]   green_sum,
    input  logic [csm_pkg::BLUE_W-1:0]    blue_sum,
    input  logic                          at_border
);
    import csm_pkg::*;

    localparam logic [RED_W-1:0]   RED_MAX   = RED_W'(93);
    localparam logic [GREEN_W-1:0] GREEN_MAX = GREEN_W'(189);
    localparam logic [BLUE_W-1:0]  BLUE_MAX  = BLUE_W'(93);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable({red_sum, green_sum, blue_sum, at_border}))
        else $error("output word changed while stalled");

    a_border_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && at_border |-> red_sum == '0 && green_sum == '0 && blue_sum == '0)
        else $error("margin result carries nonzero sums");

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> red_sum <= RED_MAX && green_sum <= GREEN_MAX && blue_sum <= BLUE_MAX)
        else $error("channel sum above three full-scale texels");

endmodule

bind three_tap_color_map_sampler_top csm_checker u_checker (.*);

// File: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csm_pkg::*;

    localparam int SETTLE_CYCLES = 30;
    localparam int PHASE_WORDS   = 210;

    typedef struct packed
    {
        logic                 cmd;
        logic [COORD_W-1:0]   cx;
        logic [COORD_W-1:0]   cy;
        logic [INDEX_W-1:0]   idx;
        logic [COMP_W-1:0]    r;
        logic [COMP_W-1:0]    g;
        logic [COMP_W-1:0]    b;
    } in_word_t;

    typedef struct packed
    {
        logic [RED_W-1:0]     red;
        logic [GREEN_W-1:0]   green;
        logic [BLUE_W-1:0]    blue;
        logic                 border;
    } color_sum_t;

    typedef enum logic
    {
        ROW_WORD,
        ROW_SIZE
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t            kind;
        in_word_t             w;
        logic                 typed;
        color_sum_t           want;
        logic [CFG_W-1:0]     size_w;
        logic [CFG_W-1:0]     size_h;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 cmd;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;
    logic [INDEX_W-1:0]   texel_index;
    logic [COMP_W-1:0]    red_in;
    logic [COMP_W-1:0]    green_in;
    logic [COMP_W-1:0]    blue_in;
    logic                 out_valid;
    logic                 out_stall;
    logic [RED_W-1:0]     red_sum;
    logic [GREEN_W-1:0]   green_sum;
    logic [BLUE_W-1:0]    blue_sum;
    logic                 at_border;

    logic [TEXEL_W-1:0]   texel_copy [0:STORE_DEPTH-1];
    bit                   texel_written [0:STORE_DEPTH-1];
    logic [CFG_W-1:0]     map_w_raw;
    logic [CFG_W-1:0]     map_h_raw;
    color_sum_t           color_queue [$];
    int unsigned          words_sent;
    int unsigned          mismatch_count;
    int unsigned          send_idle_pct;
    int unsigned          recv_stall_pct;

    three_tap_color_map_sampler_top uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .texel_index (texel_index),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_sum     (red_sum),
        .green_sum   (green_sum),
        .blue_sum    (blue_sum),
        .at_border   (at_border)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned side_in_use(input logic [CFG_W-1:0] raw);
        if (raw < MIN_SIDE)
        begin
            return MIN_SIDE;
        end
        if (raw > MAX_SIDE)
        begin
            return MAX_SIDE;
        end
        return raw;
    endfunction

    // base tap, tap at rounded x, tap at rounded y
    function automatic void tap_addresses(input logic [COORD_W-1:0] cx,
                                          input logic [COORD_W-1:0] cy,
                                          output int unsigned a0,
                                          output int unsigned a1,
                                          output int unsigned a2);
        int unsigned w;
        int unsigned h;
        int unsigned bx;
        int unsigned by;
        int unsigned rx;
        int unsigned ry;
        w = side_in_use(map_w_raw);
        h = side_in_use(map_h_raw);
        bx = (int'(cx) * w) >> FRAC_W;
        by = (int'(cy) * h) >> FRAC_W;
        rx = (int'(cx) * w + HALF_ULP) >> FRAC_W;
        ry = (int'(cy) * h + HALF_ULP) >> FRAC_W;
        if (bx < 1)
        begin
            bx = 1;
        end
        if (bx > w - 2)
        begin
            bx = w - 2;
        end
        if (by < 1)
        begin
            by = 1;
        end
        if (by > h - 2)
        begin
            by = h - 2;
        end
        if (rx > w - 1)
        begin
            rx = w - 1;
        end
        if (ry > h - 1)
        begin
            ry = h - 1;
        end
        a0 = by * w + bx;
        a1 = by * w + rx;
        a2 = ry * w + bx;
    endfunction

    function automatic color_sum_t predict_color(input logic [COORD_W-1:0] cx,
                                                 input logic [COORD_W-1:0] cy);
        color_sum_t   s;
        int unsigned  taps [3];
        int unsigned  rs;
        int unsigned  gs;
        int unsigned  bs;
        logic [TEXEL_W-1:0] t;
        s = '0;
        if (cx <= MARGIN_LOW || cx >= MARGIN_HIGH || cy <= MARGIN_LOW || cy >= MARGIN_HIGH)
        begin
            s.border = 1'b1;
            return s;
        end
        tap_addresses(cx, cy, taps[0], taps[1], taps[2]);
        rs = 0;
        gs = 0;
        bs = 0;
        for (int k = 0; k < 3; k++)
        begin
            t = texel_copy[taps[k]];
            rs += t[15:11];
            gs += t[10:5];
            bs += t[4:0];
        end
        s.red = RED_W'(rs);
        s.green = GREEN_W'(gs);
        s.blue = BLUE_W'(bs);
        return s;
    endfunction

    function automatic logic [COORD_W-1:0] inner_coord();
        case ($urandom_range(4))
            0: return COORD_W'(MARGIN_LOW + 1);
            1: return COORD_W'(MARGIN_HIGH - 1);
            2: return COORD_W'($urandom_range(MARGIN_LOW + 1, 2000));
            3: return COORD_W'($urandom_range(63500, MARGIN_HIGH - 1));
            default: return COORD_W'($urandom_range(MARGIN_LOW + 1, MARGIN_HIGH - 1));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] margin_coord();
        if ($urandom_range(1) == 0)
        begin
            return COORD_W'($urandom_range(0, MARGIN_LOW));
        end
        return COORD_W'($urandom_range(MARGIN_HIGH, 65535));
    endfunction

    function automatic stim_row_t write_row(input int unsigned idx, input int unsigned r,
                                            input int unsigned g, input int unsigned b);
        stim_row_t row;
        row = '0;
        row.kind = ROW_WORD;
        row.w.cmd = CMD_WRITE;
        row.w.idx = INDEX_W'(idx);
        row.w.r = COMP_W'(r);
        row.w.g = COMP_W'(g);
        row.w.b = COMP_W'(b);
        return row;
    endfunction

    function automatic stim_row_t query_row(input int unsigned cx, input int unsigned cy);
        stim_row_t row;
        row = '0;
        row.kind = ROW_WORD;
        row.w.cmd = CMD_QUERY;
        row.w.cx = COORD_W'(cx);
        row.w.cy = COORD_W'(cy);
        return row;
    endfunction

    function automatic stim_row_t fixed_row(input int unsigned cx, input int unsigned cy,
                                            input int unsigned r, input int unsigned g,
                                            input int unsigned b, input logic border);
        stim_row_t row;
        row = query_row(cx, cy);
        row.typed = 1'b1;
        row.want.red = RED_W'(r);
        row.want.green = GREEN_W'(g);
        row.want.blue = BLUE_W'(b);
        row.want.border = border;
        return row;
    endfunction

    function automatic stim_row_t size_row(input int unsigned w, input int unsigned h);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SIZE;
        row.size_w = CFG_W'(w);
        row.size_h = CFG_W'(h);
        return row;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic send_word(input in_word_t w, input logic typed, input color_sum_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= w.cmd;
        coord_x <= w.cx;
        coord_y <= w.cy;
        texel_index <= w.idx;
        red_in <= w.r;
        green_in <= w.g;
        blue_in <= w.b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (w.cmd == CMD_WRITE)
        begin
            texel_copy[w.idx] = {w.r[7:3], w.g[7:2], w.b[7:3]};
            texel_written[w.idx] = 1'b1;
        end
        else if (typed)
        begin
            color_queue.push_back(want);
        end
        else
        begin
            color_queue.push_back(predict_color(w.cx, w.cy));
        end
    endtask

    task automatic send_write(input int unsigned idx);
        stim_row_t row;
        row = write_row(idx, $urandom_range(255), $urandom_range(255), $urandom_range(255));
        send_word(row.w, 1'b0, '0);
    endtask

    task automatic send_query(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
        stim_row_t row;
        row = query_row(cx, cy);
        send_word(row.w, 1'b0, '0);
    endtask

    task automatic set_map_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        in_valid <= 1'b0;
        while (color_queue.size() != 0)
        begin
            @(posedge clk);
        end
        // writes leave no result, so give the pipe time to drain
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_MAP_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= REG_MAP_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        map_w_raw = w;
        map_h_raw = h;
    endtask

    always @(posedge clk)
    begin
        color_sum_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (color_queue.size() == 0)
            begin
                report_mismatch($sformatf("result word with nothing pending r=%0d g=%0d b=%0d",
                                          red_sum, green_sum, blue_sum));
            end
            else
            begin
                want = color_queue.pop_front();
                if (red_sum !== want.red)
                begin
                    report_mismatch($sformatf("red_sum %0d, want %0d", red_sum, want.red));
                end
                if (green_sum !== want.green)
                begin
                    report_mismatch($sformatf("green_sum %0d, want %0d", green_sum, want.green));
                end
                if (blue_sum !== want.blue)
                begin
                    report_mismatch($sformatf("blue_sum %0d, want %0d", blue_sum, want.blue));
                end
                if (at_border !== want.border)
                begin
                    report_mismatch($sformatf("at_border %0b, want %0b", at_border, want.border));
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        stim_row_t          rows [$];
        int unsigned        pick;
        int unsigned        goal;
        int unsigned        taps [3];
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [CFG_W-1:0]   next_w;
        logic [CFG_W-1:0]   next_h;

        words_sent = 0;
        mismatch_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        map_w_raw = RESET_SIDE;
        map_h_raw = RESET_SIDE;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_MAP_WIDTH;
        cfg_data <= '0;
        in_valid <= 1'b0;
        cmd <= CMD_WRITE;
        coord_x <= '0;
        coord_y <= '0;
        texel_index <= '0;
        red_in <= '0;
        green_in <= '0;
        blue_in <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // margins on each side of each axis
        rows.push_back(fixed_row(MARGIN_LOW, 32768, 0, 0, 0, 1'b1));
        rows.push_back(fixed_row(MARGIN_HIGH, 32768, 0, 0, 0, 1'b1));
        rows.push_back(fixed_row(32768, MARGIN_LOW, 0, 0, 0, 1'b1));
        rows.push_back(fixed_row(32768, MARGIN_HIGH, 0, 0, 0, 1'b1));
        rows.push_back(fixed_row(0, 65535, 0, 0, 0, 1'b1));
        rows.push_back(fixed_row(65535, 0, 0, 0, 0, 1'b1));
        // center of a 256x256 map: all three taps on one texel
        rows.push_back(write_row(32896, 255, 255, 255));
        rows.push_back(fixed_row(32768, 32768, 93, 189, 93, 1'b0));
        rows.push_back(write_row(65535, 8'h07, 8'h03, 8'h07));
        // low bits are dropped by the rgb565 packing
        rows.push_back(write_row(32896, 8'h07, 8'h03, 8'h07));
        rows.push_back(fixed_row(32768, 32768, 0, 0, 0, 1'b0));
        // sizes below the minimum act as 4x4: floor and rounded clamps
        rows.push_back(size_row(0, 3));
        rows.push_back(write_row(5, 8'hF8, 8'h00, 8'h00));
        rows.push_back(write_row(4, 8'h00, 8'hFC, 8'h00));
        rows.push_back(write_row(1, 8'h00, 8'h00, 8'hF8));
        rows.push_back(write_row(10, 8'h80, 8'h40, 8'h20));
        rows.push_back(write_row(11, 8'h18, 8'hA4, 8'h58));
        rows.push_back(write_row(14, 8'hFF, 8'hFF, 8'h00));
        rows.push_back(query_row(MARGIN_LOW + 1, MARGIN_LOW + 1));
        rows.push_back(query_row(MARGIN_HIGH - 1, MARGIN_HIGH - 1));
        // sizes above the maximum act as 256
        rows.push_back(size_row(511, 257));
        rows.push_back(write_row(64770, 8'h33, 8'h66, 8'h99));
        rows.push_back(write_row(64771, 8'hCC, 8'h99, 8'h66));
        rows.push_back(query_row(MARGIN_LOW + 1, MARGIN_HIGH - 1));

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_SIZE)
            begin
                set_map_size(rows[i].size_w, rows[i].size_h);
            end
            else
            begin
                send_word(rows[i].w, rows[i].typed, rows[i].want);
            end
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    next_w = CFG_W'(MAX_SIDE);
                    next_h = CFG_W'(MIN_SIDE);
                end
                1:
                begin
                    next_w = CFG_W'(MIN_SIDE);
                    next_h = CFG_W'(MAX_SIDE);
                end
                2:
                begin
                    next_w = CFG_W'($urandom_range(MIN_SIDE, MAX_SIDE));
                    next_h = CFG_W'($urandom_range(MIN_SIDE, MAX_SIDE));
                end
                default:
                begin
                    next_w = CFG_W'($urandom_range(0, 511));
                    next_h = CFG_W'($urandom_range(0, 511));
                end
            endcase
            set_map_size(next_w, next_h);
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 81;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 81;
                end
                default:
                begin
                    send_idle_pct = 15;
                    recv_stall_pct = 15;
                end
            endcase
            goal = words_sent + PHASE_WORDS;
            while (words_sent < goal)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                begin
                    send_write($urandom_range(65535));
                end
                else if (pick < 20)
                begin
                    if ($urandom_range(1) == 0)
                    begin
                        send_query(margin_coord(), COORD_W'($urandom_range(65535)));
                    end
                    else
                    begin
                        send_query(COORD_W'($urandom_range(65535)), margin_coord());
                    end
                end
                else
                begin
                    // fill the three taps first, then sample
                    cx = inner_coord();
                    cy = inner_coord();
                    tap_addresses(cx, cy, taps[0], taps[1], taps[2]);
                    for (int k = 0; k < 3; k++)
                    begin
                        if (!texel_written[taps[k]] || $urandom_range(3) == 0)
                        begin
                            send_write(taps[k]);
                        end
                    end
                    send_query(cx, cy);
                end
            end
        end

        in_valid <= 1'b0;
        while (color_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
